>>> rtl/core/gdm_pkg.sv
// Shared constants and types for the granular delay mixer.
package gdm_pkg;

  localparam int BUFFER_DEPTH_DEF = 262144;
  localparam int MAX_GRAINS_DEF   = 32;

  localparam int SAMPLE_W   = 16;
  localparam int INTERVAL_W = 16;
  localparam int LEN_W      = 19;
  localparam int START_W    = 18;
  localparam int MIX_W      = 21;
  localparam int COUNT_W    = 6;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 32;

  localparam logic [INTERVAL_W-1:0] COUNTER_MAX = '1;
  localparam int MIX_MAX = 1048575;
  localparam int MIX_MIN = -1048576;

  // reciprocal scale for the start index reduction
  localparam int MOD_SHIFT = 36;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD_MUL,
    ST_MOD_SCALE,
    ST_MOD_FIX,
    ST_LOOP,
    ST_DONE
  } gdm_state_t;

endpackage

>>> rtl/core/granular_delay_mixer.sv
// Granular delay mixer: circular sample store, grain pool and sequenced mix.
//
// Usage: one input word per audio sample on the s_ channel carries the sample
// and the current grain controls; one output word per input word on the m_
// channel carries the grain mix and the pool size after that step.
// Steps: an accepted word goes straight to the grain walk, or, when a grain is
// spawned, first through the start index reduction (multiply, scale, fix, on
// one multiplier). The walk does one grain memory read and one sample store
// read per cycle, pipelined over three stages.
// s_tready is high only while the sequencer is idle; one sample is in work at
// a time.
// Reset clears pointers, counters and the pool at once. The sample store has
// no clearing pass: a fill count marks unwritten entries, which read as zero.
// If the receiver stalls, the finished word holds in the output register; the
// next input word is still taken and worked, then waits until the register
// frees.
module granular_delay_mixer #(
  parameter int BUFFER_DEPTH = gdm_pkg::BUFFER_DEPTH_DEF,
  parameter int MAX_GRAINS   = gdm_pkg::MAX_GRAINS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // audio_sample, spawn_interval, grain_len, start_position
  input  logic [gdm_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // mix_out, grain_count
  output logic [gdm_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import gdm_pkg::*;

  localparam int AW     = $clog2(BUFFER_DEPTH);
  localparam int FW     = $clog2(BUFFER_DEPTH + 1);
  localparam int SW     = (MAX_GRAINS > 1) ? $clog2(MAX_GRAINS) : 1;
  localparam int CW     = $clog2(MAX_GRAINS + 1);
  localparam int ACC_W  = (17 + $clog2(MAX_GRAINS) > MIX_W + 1) ?
                          17 + $clog2(MAX_GRAINS) : MIX_W + 1;
  localparam longint RECIP = (64'd1 << MOD_SHIFT) / BUFFER_DEPTH;
  localparam int RW     = $clog2(RECIP + 1);
  localparam int PW     = START_W + RW;

  localparam logic [AW-1:0] LAST_ADDR = AW'(BUFFER_DEPTH - 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_GRAINS - 1);
  localparam logic [CW-1:0] POOL_MAX  = CW'(MAX_GRAINS);
  localparam logic [FW-1:0] FILL_MAX  = FW'(BUFFER_DEPTH);
  localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(MIX_MAX);
  localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(MIX_MIN);

  typedef struct packed {
    logic [AW-1:0]    start_mod;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] pos;
    logic [AW-1:0]    idx;
  } grain_t;

  // input fields
  logic [SAMPLE_W-1:0]   in_sample;
  logic [INTERVAL_W-1:0] in_interval;
  logic [LEN_W-1:0]      in_len;
  logic [START_W-1:0]    in_start;
  assign in_sample   = s_tdata[15:0];
  assign in_interval = s_tdata[31:16];
  assign in_len      = s_tdata[50:32];
  assign in_start    = s_tdata[68:51];

  gdm_state_t state, state_next;

  // control registers
  logic [AW-1:0]         wp;
  logic [FW-1:0]         fill;
  logic [INTERVAL_W-1:0] spawn_cnt;
  logic [SW-1:0]         oldest;
  logic [CW-1:0]         pool_count;
  logic [CW-1:0]         issue_cnt;
  logic [SW-1:0]         rd_slot;
  logic                  v1, v2;
  logic                  out_valid;

  // payload registers
  logic [START_W-1:0]      start_r;
  logic [LEN_W-1:0]        len_r;
  logic [SW-1:0]           spawn_slot;
  logic [PW-1:0]           prod;
  logic [START_W-1:0]      qd;
  logic [SW-1:0]           s1_slot;
  grain_t                  g_rd;
  logic signed [SAMPLE_W-1:0] a_rd;
  logic                    a_ok;
  logic signed [ACC_W-1:0] acc;
  logic [MIX_W-1:0]        mix_r;
  logic [COUNT_W-1:0]      count_r;

  logic [SAMPLE_W-1:0] amem [BUFFER_DEPTH];
  grain_t              gmem [MAX_GRAINS];

  logic accept, spawn_now, out_load, issue;
  logic [SW-1:0]  slot_new, oldest_new;
  logic [CW-1:0]  count_new;
  logic [SW:0]    slot_sum;
  logic [START_W-1:0] r_raw, r_fix;
  logic [LEN_W:0] pos_inc;
  grain_t         g_wb;
  logic [MIX_W-1:0] mix_sat;

  assign accept    = s_tvalid && s_tready;
  assign spawn_now = (spawn_cnt >= in_interval) && (in_len != '0);
  assign issue     = (state == ST_LOOP) && (issue_cnt < pool_count);

  always_comb begin
    slot_sum   = (SW + 1)'(oldest) + (SW + 1)'(pool_count);
    slot_new   = oldest;
    oldest_new = oldest;
    count_new  = pool_count;
    if (spawn_now) begin
      if (pool_count >= POOL_MAX) begin
        slot_new   = oldest;
        oldest_new = (oldest == LAST_SLOT) ? '0 : oldest + 1'b1;
      end else begin
        slot_new  = (slot_sum >= (SW + 1)'(MAX_GRAINS)) ?
                    SW'(slot_sum - (SW + 1)'(MAX_GRAINS)) : SW'(slot_sum);
        count_new = pool_count + 1'b1;
      end
    end
  end

  // start index reduction remainder
  always_comb begin
    r_raw = start_r - qd;
    r_fix = ((START_W + 1)'(r_raw) >= (START_W + 1)'(BUFFER_DEPTH)) ?
            START_W'((START_W + 1)'(r_raw) - (START_W + 1)'(BUFFER_DEPTH)) : r_raw;
  end

  // grain advance
  always_comb begin
    pos_inc = (LEN_W + 1)'(g_rd.pos) + 1'b1;
    g_wb    = g_rd;
    if (pos_inc >= (LEN_W + 1)'(g_rd.len)) begin
      g_wb.pos = '0;
      g_wb.idx = g_rd.start_mod;
    end else begin
      g_wb.pos = LEN_W'(pos_inc);
      g_wb.idx = (g_rd.idx == LAST_ADDR) ? '0 : g_rd.idx + 1'b1;
    end
  end

  always_comb begin
    if (acc > ACC_HI) begin
      mix_sat = MIX_W'(ACC_HI);
    end else if (acc < ACC_LO) begin
      mix_sat = MIX_W'(ACC_LO);
    end else begin
      mix_sat = MIX_W'(acc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = spawn_now ? ST_MOD_MUL : ST_LOOP;
        end
      end
      ST_MOD_MUL:   state_next = ST_MOD_SCALE;
      ST_MOD_SCALE: state_next = ST_MOD_FIX;
      ST_MOD_FIX:   state_next = ST_LOOP;
      ST_LOOP: begin
        if (!issue && !v1 && !v2) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      fill       <= '0;
      spawn_cnt  <= '0;
      oldest     <= '0;
      pool_count <= '0;
      issue_cnt  <= '0;
      rd_slot    <= '0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        wp   <= (wp == LAST_ADDR) ? '0 : wp + 1'b1;
        fill <= (fill == FILL_MAX) ? fill : fill + 1'b1;
        if (spawn_now) begin
          spawn_cnt <= INTERVAL_W'(1);
        end else if (spawn_cnt != COUNTER_MAX) begin
          spawn_cnt <= spawn_cnt + 1'b1;
        end
        oldest     <= oldest_new;
        pool_count <= count_new;
        rd_slot    <= oldest_new;
        issue_cnt  <= '0;
      end else if (issue) begin
        rd_slot   <= (rd_slot == LAST_SLOT) ? '0 : rd_slot + 1'b1;
        issue_cnt <= issue_cnt + 1'b1;
      end
      v1 <= issue;
      v2 <= v1;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      start_r    <= in_start;
      len_r      <= in_len;
      spawn_slot <= slot_new;
      acc        <= '0;
    end else if (v2) begin
      acc <= acc + (a_ok ? ACC_W'(a_rd) : ACC_W'(0));
    end
    prod    <= PW'(start_r) * PW'(RECIP);
    qd      <= START_W'(START_W'(prod >> MOD_SHIFT) * (AW + 1)'(BUFFER_DEPTH));
    s1_slot <= rd_slot;
    a_ok    <= (FW'(g_rd.idx) < fill);
    if (out_load) begin
      mix_r   <= mix_sat;
      count_r <= COUNT_W'(pool_count);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      amem[wp] <= in_sample;
    end
    a_rd <= amem[g_rd.idx];
  end

  always_ff @(posedge clk) begin
    if (state == ST_MOD_FIX) begin
      gmem[spawn_slot] <= '{start_mod: AW'(r_fix), len: len_r, pos: '0, idx: AW'(r_fix)};
    end else if (v1) begin
      gmem[s1_slot] <= g_wb;
    end
    g_rd <= gmem[rd_slot];
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(OUT_TDATA_W - MIX_W - COUNT_W)'(0), count_r, mix_r};

  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    pool_count <= POOL_MAX)
    else $error("pool count above capacity");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    issue_cnt <= pool_count)
    else $error("grain walk ran past pool");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("ready while a sample is in work");

  a_pipe_in_loop: assert property (@(posedge clk) disable iff (rst)
    (v1 || v2) |-> (state == ST_LOOP))
    else $error("grain pipeline active outside the walk");

  a_start_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOD_FIX) |-> ((START_W + 1)'(r_fix) < (START_W + 1)'(BUFFER_DEPTH)))
    else $error("start index not reduced");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_MAX)
    else $error("fill count above depth");

endmodule
